@@ sv/gsw_pkg.sv @@
// gsw_pkg: shared types, constants and mode tables of the grid slot walker
// used by gsw_csr, gsw_advance and grid_slot_walker_core; depends on nothing

package gsw_pkg;

   // largest item count of one arrangement
   localparam logic [12:0] MaxItems = 13'd4096;

   // walk modes with a walk of their own, and the last valid mode
   localparam logic [3:0] ModePair   = 4'd8;
   localparam logic [3:0] ModeBorder = 4'd9;
   localparam logic [3:0] ModeLast   = 4'd10;

   // register reset values
   localparam logic [3:0]  ResetWalkMode    = 4'd0;
   localparam logic [9:0]  ResetCellWidth   = 10'd75;
   localparam logic [9:0]  ResetCellHeight  = 10'd75;
   localparam logic [9:0]  ResetGlyphWidth  = 10'd32;
   localparam logic [9:0]  ResetGlyphHeight = 10'd32;
   localparam logic [13:0] ResetAreaRight   = 14'd1024;
   localparam logic [13:0] ResetAreaBottom  = 14'd768;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_WALK_MODE    = 3'd0,
      CSR_CELL_WIDTH   = 3'd1,
      CSR_CELL_HEIGHT  = 3'd2,
      CSR_GLYPH_WIDTH  = 3'd3,
      CSR_GLYPH_HEIGHT = 3'd4,
      CSR_AREA_RIGHT   = 3'd5,
      CSR_AREA_BOTTOM  = 3'd6
   } csr_index_type;

   // one step along an axis
   typedef enum logic [1:0] {
      STEP_ZERO  = 2'd0,
      STEP_PLUS  = 2'd1,
      STEP_MINUS = 2'd2
   } step_type;

   // start corner and step directions of a mode
   typedef struct packed {
      logic     corner_x;
      logic     corner_y;
      step_type step1_x;
      step_type step1_y;
      step_type step2_x;
      step_type step2_y;
   } walk_type;

   // configuration as the walk logic sees it, with derived values
   typedef struct packed {
      logic [3:0]         mode;     // clamped to ModeLast
      logic [9:0]         cell_w;
      logic [9:0]         cell_h;
      logic [13:0]        area_r;
      logic [13:0]        area_b;
      logic signed [11:0] span_x;   // cell_w - 2 * xoff
      logic signed [11:0] span_y;   // cell_h - 2 * yoff
      logic signed [15:0] start_x;  // start corner x of the mode
      logic signed [15:0] start_y;
   } cfg_type;

   // mode table
   function automatic walk_type walk_lookup(input logic [3:0] mode);
      walk_type w;
      begin
         case (mode)
            4'd0: w = '{1'b0, 1'b0, STEP_ZERO,  STEP_PLUS,  STEP_PLUS,  STEP_ZERO};
            4'd1: w = '{1'b0, 1'b0, STEP_PLUS,  STEP_ZERO,  STEP_ZERO,  STEP_PLUS};
            4'd2: w = '{1'b1, 1'b0, STEP_MINUS, STEP_ZERO,  STEP_ZERO,  STEP_PLUS};
            4'd3: w = '{1'b1, 1'b0, STEP_ZERO,  STEP_PLUS,  STEP_MINUS, STEP_ZERO};
            4'd4: w = '{1'b0, 1'b1, STEP_ZERO,  STEP_MINUS, STEP_PLUS,  STEP_ZERO};
            4'd5: w = '{1'b0, 1'b1, STEP_PLUS,  STEP_ZERO,  STEP_ZERO,  STEP_MINUS};
            4'd6: w = '{1'b1, 1'b1, STEP_MINUS, STEP_ZERO,  STEP_ZERO,  STEP_MINUS};
            4'd7: w = '{1'b1, 1'b1, STEP_ZERO,  STEP_MINUS, STEP_MINUS, STEP_ZERO};
            4'd8: w = '{1'b0, 1'b0, STEP_ZERO,  STEP_PLUS,  STEP_PLUS,  STEP_ZERO};
            default: w = '{1'b0, 1'b0, STEP_PLUS, STEP_ZERO, STEP_ZERO, STEP_PLUS};
         endcase
         return w;
      end
   endfunction

   // derived configuration from the raw register values
   function automatic cfg_type derive_cfg(
      input logic [3:0]  mode,
      input logic [9:0]  cell_w,
      input logic [9:0]  cell_h,
      input logic [9:0]  glyph_w,
      input logic [9:0]  glyph_h,
      input logic [13:0] area_r,
      input logic [13:0] area_b
   );
      cfg_type            c;
      walk_type           w;
      logic signed [10:0] dx;
      logic signed [10:0] dy;
      logic signed [10:0] adj_x;
      logic signed [10:0] adj_y;
      logic signed [10:0] xoff;
      logic signed [10:0] yoff;
      logic signed [15:0] edge_x;
      logic signed [15:0] edge_y;
      begin
         c.mode   = (mode > ModeLast) ? ModeLast : mode;
         w        = walk_lookup(c.mode);
         c.cell_w = cell_w;
         c.cell_h = cell_h;
         c.area_r = area_r;
         c.area_b = area_b;
         // centering offsets, halved toward zero
         dx    = $signed({1'b0, cell_w}) - $signed({1'b0, glyph_w});
         dy    = $signed({1'b0, cell_h}) - $signed({1'b0, glyph_h});
         adj_x = dx + $signed({10'd0, dx[10]});
         adj_y = dy + $signed({10'd0, dy[10]});
         xoff  = adj_x >>> 1;
         yoff  = adj_y >>> 1;
         c.span_x = $signed({2'b00, cell_w}) - $signed({xoff, 1'b0});
         c.span_y = $signed({2'b00, cell_h}) - $signed({yoff, 1'b0});
         // start corner
         edge_x = w.corner_x ? ($signed({2'b00, area_r}) - $signed({6'd0, cell_w})) : 16'sd0;
         edge_y = w.corner_y ? ($signed({2'b00, area_b}) - $signed({6'd0, cell_h})) : 16'sd0;
         c.start_x = edge_x + $signed({{5{xoff[10]}}, xoff});
         c.start_y = edge_y + $signed({{5{yoff[10]}}, yoff});
         return c;
      end
   endfunction

endpackage

@@ sv/grid_slot_walker_core.sv @@
// grid_slot_walker_core: hands out grid slots, one per requested item
// latency: a result is valid in the cycle after its item is accepted
// throughput: one item per cycle unless a held result stalls the request; the walk state and the result register
// update together at the accepting edge, the result register frees on take
// reset (synchronous): walk state cleared, no result pending, registers to defaults
// depends on gsw_pkg, gsw_csr and gsw_advance

module grid_slot_walker_core
   import gsw_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   input  logic               req_descending,
   input  logic [12:0]        req_item_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_item_index,
   output logic signed [15:0] rsp_slot_x,
   output logic signed [15:0] rsp_slot_y,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [13:0]        csr_data
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   cfg_type cfg;

   // walk state
   coord_type   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type   org_x_ff, org_x_in, org_y_ff, org_y_in;
   coord_type   bdr_x_ff, bdr_x_in, bdr_y_ff, bdr_y_in;
   logic [1:0]  phase_ff, phase_in;
   logic [11:0] index_ff, index_in;
   logic [12:0] remain_ff, remain_in;
   logic        down_ff, down_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        rsp_index_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_last_ff;

   // state as seen by this item, after a possible restart
   coord_type   s_x, s_y, start_x, start_y;
   logic [1:0]  s_phase;
   logic [11:0] s_index;
   logic [12:0] s_remain, count_sat;
   logic        s_down, accept, emit;
   logic signed [47:0] start_x_w, start_y_w;
   logic signed [31:0] out_x_w, out_y_w;

   coord_type   adv_cur_x, adv_cur_y, adv_org_x, adv_org_y, adv_bdr_x, adv_bdr_y;
   coord_type   s_org_x, s_org_y, s_bdr_x, s_bdr_y;
   logic [1:0]  adv_phase;

   gsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // handshake: take an item unless a waiting result is held
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // start point at coordinate width
   assign start_x_w = 48'(cfg.start_x);
   assign start_y_w = 48'(cfg.start_y);
   assign start_x   = start_x_w[COORD_BITS-1:0];
   assign start_y   = start_y_w[COORD_BITS-1:0];
   assign count_sat = (req_item_count > MaxItems) ? MaxItems : req_item_count;

   // restart reload
   always_comb begin
      if (req_restart) begin
         s_x      = start_x;
         s_y      = start_y;
         s_org_x  = start_x;
         s_org_y  = start_y;
         s_bdr_x  = start_x;
         s_bdr_y  = start_y;
         s_phase  = 2'd0;
         s_remain = count_sat;
         s_down   = req_descending;
         s_index  = req_descending ? 12'(count_sat - 13'd1) : 12'd0;
      end else begin
         s_x      = cur_x_ff;
         s_y      = cur_y_ff;
         s_org_x  = org_x_ff;
         s_org_y  = org_y_ff;
         s_bdr_x  = bdr_x_ff;
         s_bdr_y  = bdr_y_ff;
         s_phase  = phase_ff;
         s_remain = remain_ff;
         s_down   = down_ff;
         s_index  = index_ff;
      end
   end

   assign emit = accept && (s_remain != 13'd0);

   gsw_advance #(
      .COORD_BITS (COORD_BITS)
   ) u_advance (
      .cfg     (cfg),
      .cur_x_i (s_x),
      .cur_y_i (s_y),
      .org_x_i (s_org_x),
      .org_y_i (s_org_y),
      .bdr_x_i (s_bdr_x),
      .bdr_y_i (s_bdr_y),
      .phase_i (s_phase),
      .cur_x_o (adv_cur_x),
      .cur_y_o (adv_cur_y),
      .org_x_o (adv_org_x),
      .org_y_o (adv_org_y),
      .bdr_x_o (adv_bdr_x),
      .bdr_y_o (adv_bdr_y),
      .phase_o (adv_phase)
   );

   // walk state update
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      org_x_in  = org_x_ff;
      org_y_in  = org_y_ff;
      bdr_x_in  = bdr_x_ff;
      bdr_y_in  = bdr_y_ff;
      phase_in  = phase_ff;
      index_in  = index_ff;
      remain_in = remain_ff;
      down_in   = down_ff;
      if (emit) begin
         cur_x_in  = adv_cur_x;
         cur_y_in  = adv_cur_y;
         org_x_in  = adv_org_x;
         org_y_in  = adv_org_y;
         bdr_x_in  = adv_bdr_x;
         bdr_y_in  = adv_bdr_y;
         phase_in  = adv_phase;
         index_in  = s_down ? (s_index - 12'd1) : (s_index + 12'd1);
         remain_in = s_remain - 13'd1;
         down_in   = s_down;
      end else if (accept) begin
         cur_x_in  = s_x;
         cur_y_in  = s_y;
         org_x_in  = s_org_x;
         org_y_in  = s_org_y;
         bdr_x_in  = s_bdr_x;
         bdr_y_in  = s_bdr_y;
         phase_in  = s_phase;
         index_in  = s_index;
         remain_in = s_remain;
         down_in   = s_down;
      end
   end

   // result valid: set on a new result, cleared when taken
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   assign out_x_w = 32'(s_x);
   assign out_y_w = 32'(s_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         bdr_x_ff     <= '0;
         bdr_y_ff     <= '0;
         phase_ff     <= 2'd0;
         index_ff     <= 12'd0;
         remain_ff    <= 13'd0;
         down_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         org_x_ff     <= org_x_in;
         org_y_ff     <= org_y_in;
         bdr_x_ff     <= bdr_x_in;
         bdr_y_ff     <= bdr_y_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         remain_ff    <= remain_in;
         down_ff      <= down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= s_index;
         rsp_x_ff     <= out_x_w[15:0];
         rsp_y_ff     <= out_y_w[15:0];
         rsp_last_ff  <= (s_remain == 13'd1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_index = rsp_index_ff;
   assign rsp_slot_x     = rsp_x_ff;
   assign rsp_slot_y     = rsp_y_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ sv/gsw_csr.sv @@
// gsw_csr: configuration registers of the grid slot walker and their derived values
// depends on gsw_pkg

module gsw_csr
   import gsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_data,
   output cfg_type     cfg
);

   logic [3:0]  walk_mode_ff,    walk_mode_in;
   logic [9:0]  cell_width_ff,   cell_width_in;
   logic [9:0]  cell_height_ff,  cell_height_in;
   logic [9:0]  glyph_width_ff,  glyph_width_in;
   logic [9:0]  glyph_height_ff, glyph_height_in;
   logic [13:0] area_right_ff,   area_right_in;
   logic [13:0] area_bottom_ff,  area_bottom_in;
   cfg_type     cfg_ff,          cfg_in;

   // register write decode, values masked to register widths
   always_comb begin
      walk_mode_in    = walk_mode_ff;
      cell_width_in   = cell_width_ff;
      cell_height_in  = cell_height_ff;
      glyph_width_in  = glyph_width_ff;
      glyph_height_in = glyph_height_ff;
      area_right_in   = area_right_ff;
      area_bottom_in  = area_bottom_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WALK_MODE:    walk_mode_in    = csr_data[3:0];
            CSR_CELL_WIDTH:   cell_width_in   = csr_data[9:0];
            CSR_CELL_HEIGHT:  cell_height_in  = csr_data[9:0];
            CSR_GLYPH_WIDTH:  glyph_width_in  = csr_data[9:0];
            CSR_GLYPH_HEIGHT: glyph_height_in = csr_data[9:0];
            CSR_AREA_RIGHT:   area_right_in   = csr_data;
            CSR_AREA_BOTTOM:  area_bottom_in  = csr_data;
            default: ;
         endcase
      end
   end

   // derived values follow the new register values in the same cycle
   assign cfg_in = derive_cfg(walk_mode_in, cell_width_in, cell_height_in,
                              glyph_width_in, glyph_height_in,
                              area_right_in, area_bottom_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_mode_ff    <= ResetWalkMode;
         cell_width_ff   <= ResetCellWidth;
         cell_height_ff  <= ResetCellHeight;
         glyph_width_ff  <= ResetGlyphWidth;
         glyph_height_ff <= ResetGlyphHeight;
         area_right_ff   <= ResetAreaRight;
         area_bottom_ff  <= ResetAreaBottom;
         cfg_ff          <= derive_cfg(ResetWalkMode, ResetCellWidth, ResetCellHeight,
                                       ResetGlyphWidth, ResetGlyphHeight,
                                       ResetAreaRight, ResetAreaBottom);
      end else begin
         walk_mode_ff    <= walk_mode_in;
         cell_width_ff   <= cell_width_in;
         cell_height_ff  <= cell_height_in;
         glyph_width_ff  <= glyph_width_in;
         glyph_height_ff <= glyph_height_in;
         area_right_ff   <= area_right_in;
         area_bottom_ff  <= area_bottom_in;
         cfg_ff          <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/gsw_advance.sv @@
// gsw_advance: combinational next-slot logic of the grid slot walker
// depends on gsw_pkg

module gsw_advance
   import gsw_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  cfg_type                       cfg,
   input  logic signed [COORD_BITS-1:0]  cur_x_i,
   input  logic signed [COORD_BITS-1:0]  cur_y_i,
   input  logic signed [COORD_BITS-1:0]  org_x_i,
   input  logic signed [COORD_BITS-1:0]  org_y_i,
   input  logic signed [COORD_BITS-1:0]  bdr_x_i,
   input  logic signed [COORD_BITS-1:0]  bdr_y_i,
   input  logic [1:0]                    phase_i,
   output logic signed [COORD_BITS-1:0]  cur_x_o,
   output logic signed [COORD_BITS-1:0]  cur_y_o,
   output logic signed [COORD_BITS-1:0]  org_x_o,
   output logic signed [COORD_BITS-1:0]  org_y_o,
   output logic signed [COORD_BITS-1:0]  bdr_x_o,
   output logic signed [COORD_BITS-1:0]  bdr_y_o,
   output logic [1:0]                    phase_o
);

   // compare width: coordinate plus span and area without overflow
   localparam int EW = COORD_BITS + 5;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EW-1:0]         wide_type;

   function automatic coord_type wrap_c(input wide_type v);
      return v[COORD_BITS-1:0];
   endfunction

   function automatic wide_type widen(input coord_type v);
      return EW'(v);
   endfunction

   function automatic wide_type step_delta(input step_type s, input wide_type d);
      wide_type r;
      begin
         case (s)
            STEP_PLUS:  r = d;
            STEP_MINUS: r = -d;
            default:    r = '0;
         endcase
         return r;
      end
   endfunction

   walk_type  walk;
   wide_type  cxw, cyw, rw, bw, spxw, spyw;
   coord_type nx, ny, nx2, ny2;
   logic      x_over, y_over;
   logic [1:0] phase_n;
   coord_type mirror_x, pair_y, bx, by, ox, oy;
   logic      pair_over, bx_over, by_over;
   logic      special;

   assign walk = walk_lookup(cfg.mode);
   assign cxw  = wide_type'({{(EW-10){1'b0}}, cfg.cell_w});
   assign cyw  = wide_type'({{(EW-10){1'b0}}, cfg.cell_h});
   assign rw   = wide_type'({{(EW-14){1'b0}}, cfg.area_r});
   assign bw   = wide_type'({{(EW-14){1'b0}}, cfg.area_b});
   assign spxw = EW'(cfg.span_x);
   assign spyw = EW'(cfg.span_y);

   // plain walk: primary step, fall back at the work area edge
   assign nx     = wrap_c(widen(cur_x_i) + step_delta(walk.step1_x, cxw));
   assign ny     = wrap_c(widen(cur_y_i) + step_delta(walk.step1_y, cyw));
   assign x_over = (nx < 0) || (widen(nx) + spxw > rw);
   assign y_over = (ny < 0) || (widen(ny) + spyw > bw);
   assign ny2    = wrap_c(widen(ny) + step_delta(walk.step2_y, cyw));
   assign nx2    = wrap_c(widen(nx) + step_delta(walk.step2_x, cxw));

   // mirrored-column and border walks
   assign phase_n   = phase_i + 2'd1;
   assign mirror_x  = wrap_c(rw - widen(cur_x_i) - spxw);
   assign pair_y    = wrap_c(widen(cur_y_i) + cyw);
   assign pair_over = widen(pair_y) + spyw > bw;
   assign bx        = wrap_c(widen(bdr_x_i) + cxw);
   assign by        = wrap_c(widen(bdr_y_i) + cyw);
   assign bx_over   = widen(bx) + spxw > rw;
   assign by_over   = widen(by) + spyw > bw;
   assign ox        = wrap_c(widen(org_x_i) + cxw);
   assign oy        = wrap_c(widen(org_y_i) + cyw);
   assign special   = (cfg.mode == ModePair) || (cfg.mode == ModeBorder);

   // next position select
   always_comb begin
      cur_x_o = cur_x_i;
      cur_y_o = cur_y_i;
      org_x_o = org_x_i;
      org_y_o = org_y_i;
      bdr_x_o = bdr_x_i;
      bdr_y_o = bdr_y_i;
      phase_o = phase_i;
      if (special) begin
         phase_o = phase_n;
         if (phase_n[0]) begin
            cur_x_o = mirror_x;
         end else if (cfg.mode == ModePair) begin
            if (pair_over) begin
               cur_y_o = org_y_i;
               org_x_o = ox;
               cur_x_o = ox;
            end else begin
               cur_y_o = pair_y;
            end
         end else if (phase_n[1]) begin
            bdr_y_o = by;
            cur_y_o = by;
            cur_x_o = org_x_i;
            if (by_over) begin
               org_x_o = ox;
               bdr_x_o = ox;
               cur_x_o = ox;
               org_y_o = oy;
               bdr_y_o = oy;
               cur_y_o = oy;
            end
         end else begin
            bdr_x_o = bx;
            cur_x_o = bx;
            cur_y_o = org_y_i;
            if (bx_over) begin
               org_x_o = ox;
               bdr_x_o = ox;
               cur_x_o = ox;
               org_y_o = oy;
               bdr_y_o = oy;
               cur_y_o = oy;
            end
         end
      end else if (x_over) begin
         cur_x_o = org_x_i;
         cur_y_o = ny2;
      end else if (y_over) begin
         cur_y_o = org_y_i;
         cur_x_o = nx2;
      end else begin
         cur_x_o = nx;
         cur_y_o = ny;
      end
   end

endmodule
